// File: sv/cbrf_pkg.sv
// Shared types and constants for the cubic bisection root finder.
package cbrf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int INT_BITS  = 12;
	localparam int FIELD_W   = INT_BITS + FRAC_BITS;
	localparam int TOL_W     = 28;
	localparam int ITER_W    = 5;
	localparam int MAX_ITER  = 31;
	localparam int MUL_AW    = FIELD_W + 1;
	localparam int PROD_W    = 2 * FIELD_W + 1;
	localparam int ACC_W     = 3 * FIELD_W + 3;
	localparam int CMP_W     = FIELD_W + 2;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

	// 2 * 2^(2*FRAC_BITS): linear term coefficient at the square's scale
	localparam logic [PROD_W-1:0] LIN_C = {{(PROD_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 1);
	// 4 * 2^(3*FRAC_BITS): constant term at the cube's scale
	localparam logic [ACC_W-1:0] ACC_K = {{(ACC_W-1){1'b0}}, 1'b1} << (3 * FRAC_BITS + 2);

	typedef logic signed [FIELD_W-1:0] fix_t;

	typedef enum logic [2:0] {
		ST_CONVERGED = 3'd0,
		ST_EXACT_MID = 3'd1,
		ST_EXACT_A   = 3'd2,
		ST_EXACT_B   = 3'd3,
		ST_NO_CHANGE = 3'd4
	} status_t;

	typedef struct packed {
		fix_t lower_bound;
		fix_t upper_bound;
	} in_item_t;

	typedef struct packed {
		status_t             status;
		fix_t                root;
		fix_t                final_low;
		fix_t                final_high;
		logic [ITER_W-1:0]   iteration_count;
	} out_item_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} fsign_t;

	typedef struct packed {
		logic   done;
		fsign_t sign;
	} eval_rsp_t;

	typedef enum logic [2:0] {
		EV_IDLE,
		EV_SQ,
		EV_SUB,
		EV_HI,
		EV_LO,
		EV_SUM,
		EV_DONE
	} ev_state_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_EVAL_A,
		C_EVAL_B,
		C_CHECK,
		C_LOOP,
		C_EVAL_M,
		C_FINISH
	} ctl_state_t;

endpackage

// File: sv/cubic_bisection_root_finder_core.sv
// Top level: bisection root finder for x^3 - 2x + 4 over a Q12.16 interval.
// Each evaluation of the cubic runs on the shared multiplier unit.
// Up to 31 halving steps are done per item; a run ends early when a midpoint is an exact
// root, and none are done at an exact endpoint or without a sign change. One item at a
// time: the next input item can be taken in the cycle after the result enters the output register.
// Reset clears the control state, drops out_valid and sets tolerance to 66.
module cubic_bisection_root_finder_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  cbrf_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output cbrf_pkg::out_item_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cbrf_pkg::TOL_W-1:0] cfg_data
);
	import cbrf_pkg::*;

	ctl_state_t state_q, state_d;

	logic [TOL_W-1:0]  tol_q;
	fix_t              a_q, b_q, mid_q, root_q;
	fsign_t            sa_q, sb_q;
	logic [ITER_W-1:0] iter_q;
	status_t           status_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              ev_start;
	fix_t              ev_x;
	eval_rsp_t         ev_rsp;

	logic signed [FIELD_W:0]  sum_ab, diff_ab;
	fix_t                     mid;
	logic                     go_on;
	logic                     out_free;
	logic                     in_fire;

	cbrf_cubic_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ev_start),
		.x      (ev_x),
		.rsp    (ev_rsp)
	);

	assign sum_ab  = {a_q[FIELD_W-1], a_q} + {b_q[FIELD_W-1], b_q};
	assign mid     = sum_ab[FIELD_W:1];
	assign diff_ab = {b_q[FIELD_W-1], b_q} - {a_q[FIELD_W-1], a_q};
	assign go_on   = ($signed({diff_ab[FIELD_W], diff_ab})
			> $signed({{(CMP_W-TOL_W){1'b0}}, tol_q}))
			&& (iter_q != ITER_W'(MAX_ITER));
	assign out_free = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			C_IDLE:   if (in_valid) state_d = C_EVAL_A;
			C_EVAL_A: if (ev_rsp.done) state_d = C_EVAL_B;
			C_EVAL_B: if (ev_rsp.done) state_d = C_CHECK;
			C_CHECK: begin
				if (sa_q.zero || sb_q.zero || (sa_q.neg == sb_q.neg)) state_d = C_FINISH;
				else state_d = C_LOOP;
			end
			C_LOOP:   state_d = go_on ? C_EVAL_M : C_FINISH;
			C_EVAL_M: begin
				if (ev_rsp.done) state_d = ev_rsp.sign.zero ? C_FINISH : C_LOOP;
			end
			C_FINISH: if (out_free) state_d = C_IDLE;
			default:  state_d = C_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == C_IDLE);
		ev_start = 1'b0;
		ev_x     = a_q;
		case (state_q)
			C_EVAL_A: begin
				ev_start = 1'b1;
				ev_x     = a_q;
			end
			C_EVAL_B: begin
				ev_start = 1'b1;
				ev_x     = b_q;
			end
			C_EVAL_M: begin
				ev_start = 1'b1;
				ev_x     = mid_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			tol_q       <= TOL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) tol_q <= cfg_data;
			if (state_q == C_FINISH && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (in_fire) begin
					a_q    <= in_data.lower_bound;
					b_q    <= in_data.upper_bound;
					iter_q <= '0;
				end
			end
			C_EVAL_A: if (ev_rsp.done) sa_q <= ev_rsp.sign;
			C_EVAL_B: if (ev_rsp.done) sb_q <= ev_rsp.sign;
			C_CHECK: begin
				if (sa_q.zero) begin
					status_q <= ST_EXACT_A;
					root_q   <= a_q;
				end else if (sb_q.zero) begin
					status_q <= ST_EXACT_B;
					root_q   <= b_q;
				end else if (sa_q.neg == sb_q.neg) begin
					status_q <= ST_NO_CHANGE;
					root_q   <= '0;
				end else begin
					status_q <= ST_CONVERGED;
				end
			end
			C_LOOP: begin
				if (go_on) begin
					iter_q <= iter_q + ITER_W'(1);
					mid_q  <= mid;
				end else begin
					root_q <= mid;
				end
			end
			C_EVAL_M: begin
				if (ev_rsp.done) begin
					if (ev_rsp.sign.zero) begin
						status_q <= ST_EXACT_MID;
						root_q   <= mid_q;
					end else if (ev_rsp.sign.neg != sa_q.neg) begin
						b_q <= mid_q;
					end else begin
						a_q  <= mid_q;
						sa_q <= ev_rsp.sign;
					end
				end
			end
			C_FINISH: begin
				if (out_free) begin
					out_q.status          <= status_q;
					out_q.root            <= root_q;
					out_q.final_low       <= a_q;
					out_q.final_high      <= b_q;
					out_q.iteration_count <= iter_q;
				end
			end
			default: ;
		endcase
	end

	a_endpoint_no_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status == ST_EXACT_A || out_data.status == ST_EXACT_B
			|| out_data.status == ST_NO_CHANGE)) |-> (out_data.iteration_count == '0))
		else $error("endpoint or no-sign-change item reports halving steps");

	a_no_change_root: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_NO_CHANGE) |-> (out_data.root == '0))
		else $error("no-sign-change item with nonzero root");

	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.iteration_count != '0)
			|-> (out_data.final_low < out_data.final_high))
		else $error("bisected interval lost its ordering");

	a_eval_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_EVAL_M && ev_rsp.done) |=> (state_q != C_EVAL_M))
		else $error("midpoint evaluation result not consumed");

endmodule

// File: sv/cbrf_cubic_eval.sv
// Sign of f(x) = x^3 - 2x + 4 on one shared multiplier; done is raised after the SQ, SUB, HI, LO and SUM steps.
module cbrf_cubic_eval (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cbrf_pkg::fix_t      x,
	output cbrf_pkg::eval_rsp_t rsp
);
	import cbrf_pkg::*;

	ev_state_t ev_q, ev_d;
	fix_t                    x_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] t_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [MUL_AW-1:0] mul_a;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [ACC_W-1:0]  prod_ext;

	// F = hi(x^2 - c) * x * 2^W + lo(x^2 - c) * x + k
	assign mul_p    = mul_a * x_q;
	assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

	always_comb begin
		ev_d = ev_q;
		case (ev_q)
			EV_IDLE: if (start) ev_d = EV_SQ;
			EV_SQ:   ev_d = EV_SUB;
			EV_SUB:  ev_d = EV_HI;
			EV_HI:   ev_d = EV_LO;
			EV_LO:   ev_d = EV_SUM;
			EV_SUM:  ev_d = EV_DONE;
			EV_DONE: ev_d = EV_IDLE;
			default: ev_d = EV_IDLE;
		endcase
	end

	always_comb begin
		mul_a = {x_q[FIELD_W-1], x_q};
		case (ev_q)
			EV_HI:   mul_a = t_q[2*FIELD_W:FIELD_W];
			EV_LO:   mul_a = {1'b0, t_q[FIELD_W-1:0]};
			default: mul_a = {x_q[FIELD_W-1], x_q};
		endcase
		rsp.done      = (ev_q == EV_DONE);
		rsp.sign.neg  = acc_q[ACC_W-1];
		rsp.sign.zero = (acc_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q <= EV_IDLE;
		end else begin
			ev_q <= ev_d;
		end
	end

	always_ff @(posedge clk) begin
		case (ev_q)
			EV_IDLE: if (start) x_q <= x;
			EV_SQ:   prod_q <= mul_p;
			EV_SUB:  t_q <= prod_q - $signed(LIN_C);
			EV_HI:   prod_q <= mul_p;
			EV_LO: begin
				acc_q  <= (prod_ext <<< FIELD_W) + $signed(ACC_K);
				prod_q <= mul_p;
			end
			EV_SUM:  acc_q <= acc_q + prod_ext;
			default: ;
		endcase
	end

	a_eval_len: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_q == EV_IDLE && start) |-> ##6 rsp.done)
		else $error("cubic evaluation did not finish in six cycles");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("evaluation done held longer than one cycle");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_q == EV_SQ) |-> $past(start))
		else $error("evaluation started without a request");

endmodule
